/* hw/rtl/hsvrgb_pkg.sv */
package hsvrgb_pkg;

   // Width of one hue sector on the 0..255 wheel
   localparam int unsigned SECTOR_WIDTH = 43;
   // Scale of the offset within a sector (0..42 -> 0..252)
   localparam int unsigned OFFSET_SCALE = 6;
   // Full-scale channel level
   localparam logic [7:0] FULL_SCALE = 8'd255;
   // Right shift after each 8x8 product
   localparam int unsigned PRODUCT_SHIFT = 8;

   // Hue sector, in wheel order
   typedef enum logic [2:0] {
      REGION_RED_YELLOW,
      REGION_YELLOW_GREEN,
      REGION_GREEN_CYAN,
      REGION_CYAN_BLUE,
      REGION_BLUE_MAGENTA,
      REGION_MAGENTA_RED
   } region_type;

endpackage

/* hw/rtl/hsv_to_rgb_8bit_core.sv */
// HSV to RGB converter, 8 bits per channel, integer six-sector scheme. Takes one
// request per clock while not stalled and returns one result per request, in
// order, through four register stages (sector split with the p product, the two
// saturation products, the q and t products, then channel selection into the
// output register), each holding at most one level of 8x8 multiplies. A stall on
// rsp_stall holds the full stages at the tail of the pipeline and reaches
// req_stall in the same cycle only when no stage has a free slot.
// Saturation zero gives grey: red, green and blue all equal brightness.
module hsv_to_rgb_8bit_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_brightness,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import hsvrgb_pkg::*;

   // Stage load enables, back from the output
   logic ld1, ld2, ld3, ld4;

   // Stage 1 registers
   logic       s1_valid_ff;
   region_type s1_region_ff, s1_region_in;
   logic [7:0] s1_off_ff, s1_off_in;
   logic [7:0] s1_s_ff, s1_v_ff, s1_p_ff, s1_p_in;
   logic       s1_grey_ff;
   logic [7:0] s1_base;
   logic [15:0] s1_p_prod;

   // Stage 2 registers
   logic       s2_valid_ff;
   region_type s2_region_ff;
   logic [7:0] s2_v_ff, s2_p_ff;
   logic       s2_grey_ff;
   logic [7:0] s2_sf_ff, s2_sf_in, s2_sc_ff, s2_sc_in;
   logic [15:0] s2_sf_prod, s2_sc_prod;

   // Stage 3 registers
   logic       s3_valid_ff;
   region_type s3_region_ff;
   logic [7:0] s3_v_ff, s3_p_ff;
   logic       s3_grey_ff;
   logic [7:0] s3_q_ff, s3_q_in, s3_t_ff, s3_t_in;
   logic [15:0] s3_q_prod, s3_t_prod;

   // Output registers
   logic       rsp_valid_ff;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // Flow control: a stage loads when empty or when its successor loads
   assign ld4       = !rsp_valid_ff || !rsp_stall;
   assign ld3       = !s3_valid_ff || ld4;
   assign ld2       = !s2_valid_ff || ld3;
   assign ld1       = !s1_valid_ff || ld2;
   assign req_stall = !ld1;

   // Sector split: compare ladder against sector bounds
   always_comb begin
      if (req_hue >= 8'(SECTOR_WIDTH * 5)) begin
         s1_region_in = REGION_MAGENTA_RED;
         s1_base      = 8'(SECTOR_WIDTH * 5);
      end else if (req_hue >= 8'(SECTOR_WIDTH * 4)) begin
         s1_region_in = REGION_BLUE_MAGENTA;
         s1_base      = 8'(SECTOR_WIDTH * 4);
      end else if (req_hue >= 8'(SECTOR_WIDTH * 3)) begin
         s1_region_in = REGION_CYAN_BLUE;
         s1_base      = 8'(SECTOR_WIDTH * 3);
      end else if (req_hue >= 8'(SECTOR_WIDTH * 2)) begin
         s1_region_in = REGION_GREEN_CYAN;
         s1_base      = 8'(SECTOR_WIDTH * 2);
      end else if (req_hue >= 8'(SECTOR_WIDTH)) begin
         s1_region_in = REGION_YELLOW_GREEN;
         s1_base      = 8'(SECTOR_WIDTH);
      end else begin
         s1_region_in = REGION_RED_YELLOW;
         s1_base      = 8'd0;
      end
      // remainder is at most 42, so the scaled offset fits in 8 bits
      s1_off_in = 8'((req_hue - s1_base) * 8'(OFFSET_SCALE));
      s1_p_prod = 16'(req_brightness) * 16'(FULL_SCALE - req_saturation);
      s1_p_in   = 8'(s1_p_prod >> PRODUCT_SHIFT);
   end

   // Saturation times offset and its complement
   always_comb begin
      s2_sf_prod = 16'(s1_s_ff) * 16'(s1_off_ff);
      s2_sc_prod = 16'(s1_s_ff) * 16'(FULL_SCALE - s1_off_ff);
      s2_sf_in   = 8'(s2_sf_prod >> PRODUCT_SHIFT);
      s2_sc_in   = 8'(s2_sc_prod >> PRODUCT_SHIFT);
   end

   // Falling and rising levels q and t
   always_comb begin
      s3_q_prod = 16'(s2_v_ff) * 16'(FULL_SCALE - s2_sf_ff);
      s3_t_prod = 16'(s2_v_ff) * 16'(FULL_SCALE - s2_sc_ff);
      s3_q_in   = 8'(s3_q_prod >> PRODUCT_SHIFT);
      s3_t_in   = 8'(s3_t_prod >> PRODUCT_SHIFT);
   end

   // Channel order by sector; grey overrides
   always_comb begin
      case (s3_region_ff)
         REGION_RED_YELLOW: begin
            red_in = s3_v_ff; green_in = s3_t_ff; blue_in = s3_p_ff;
         end
         REGION_YELLOW_GREEN: begin
            red_in = s3_q_ff; green_in = s3_v_ff; blue_in = s3_p_ff;
         end
         REGION_GREEN_CYAN: begin
            red_in = s3_p_ff; green_in = s3_v_ff; blue_in = s3_t_ff;
         end
         REGION_CYAN_BLUE: begin
            red_in = s3_p_ff; green_in = s3_q_ff; blue_in = s3_v_ff;
         end
         REGION_BLUE_MAGENTA: begin
            red_in = s3_t_ff; green_in = s3_p_ff; blue_in = s3_v_ff;
         end
         default: begin
            red_in = s3_v_ff; green_in = s3_p_ff; blue_in = s3_q_ff;
         end
      endcase
      if (s3_grey_ff) begin
         red_in   = s3_v_ff;
         green_in = s3_v_ff;
         blue_in  = s3_v_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff  <= req_valid;
         if (ld2) s2_valid_ff  <= s1_valid_ff;
         if (ld3) s3_valid_ff  <= s2_valid_ff;
         if (ld4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_region_ff <= s1_region_in;
         s1_off_ff    <= s1_off_in;
         s1_s_ff      <= req_saturation;
         s1_v_ff      <= req_brightness;
         s1_p_ff      <= s1_p_in;
         s1_grey_ff   <= (req_saturation == 8'd0);
      end
      if (ld2) begin
         s2_region_ff <= s1_region_ff;
         s2_v_ff      <= s1_v_ff;
         s2_p_ff      <= s1_p_ff;
         s2_grey_ff   <= s1_grey_ff;
         s2_sf_ff     <= s2_sf_in;
         s2_sc_ff     <= s2_sc_in;
      end
      if (ld3) begin
         s3_region_ff <= s2_region_ff;
         s3_v_ff      <= s2_v_ff;
         s3_p_ff      <= s2_p_ff;
         s3_grey_ff   <= s2_grey_ff;
         s3_q_ff      <= s3_q_in;
         s3_t_ff      <= s3_t_in;
      end
      if (ld4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

`ifndef SYNTH
   // Scaled offset never exceeds 42 steps of six
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_off_ff <= 8'd252)
      else $error("sector offset out of range");

   // p is never above brightness
   a_p_below_v: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_p_ff <= s1_v_ff)
      else $error("p level above brightness");

   // A grey item leaves with three equal channels
   a_grey_out: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_grey_ff && ld4 |=> rsp_red == rsp_green && rsp_green == rsp_blue)
      else $error("grey request gave unequal channels");

   // One channel always carries brightness
   a_v_present: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && ld4 |=> rsp_red == $past(s3_v_ff) || rsp_green == $past(s3_v_ff)
         || rsp_blue == $past(s3_v_ff))
      else $error("no channel equals brightness");

   // A draining output lets the pipeline take a request
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while output drains");
`endif

endmodule

/* tb/sv/hsv_to_rgb_8bit_core_test.sv */
`timescale 1ns / 100ps

module hsv_to_rgb_8bit_core_test;
   import hsvrgb_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      bit         typed;
      rgb_type    color;
   } hsv_row_type;

   localparam int unsigned NUM_DIRECTED = 20;
   localparam int unsigned NUM_RANDOM   = 1500;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_hue = 8'd0;
   logic [7:0] req_saturation = 8'd0;
   logic [7:0] req_brightness = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;

   // Colors owed by the block, oldest first
   rgb_type expected_colors[$];
   bit   idle_enabled = 1'b1;
   int   mismatch_count = 0;
   int   requests_sent = 0;
   int   colors_checked = 0;
   int   grey_requests = 0;

   // Extremes and sector boundaries; typed rows hold colors readable by eye
   hsv_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{8'd200, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{8'd17,  8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd15}},
      '{8'd100, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{8'd42,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd43,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd85,  8'd200, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd86,  8'd200, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd128, 8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd129, 8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd171, 8'd1,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd172, 8'd1,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd214, 8'd255, 8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd215, 8'd255, 8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd255, 8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd127, 8'd127, 8'd127, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd85,  8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd240, 8'd85,  8'd240, 1'b0, '{8'd0,   8'd0,   8'd0}}
   };

   hsv_to_rgb_8bit_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Truncating 8x8 product, top byte kept
   function automatic logic [7:0] scaled_product(logic [7:0] a, logic [7:0] b);
      logic [15:0] product;
      product = 16'(a) * 16'(b);
      return product[15:8];
   endfunction

   // Six-sector integer HSV to RGB
   function automatic rgb_type convert_hsv(logic [7:0] h, logic [7:0] s, logic [7:0] v);
      int unsigned sector;
      region_type  region;
      logic [7:0]  offset;
      logic [7:0]  p;
      logic [7:0]  q;
      logic [7:0]  t;
      rgb_type     color;
      if (s == 8'd0) begin
         color = '{v, v, v};
      end else begin
         sector = h / SECTOR_WIDTH;
         region = region_type'(sector);
         offset = 8'((h - sector * SECTOR_WIDTH) * OFFSET_SCALE);
         p = scaled_product(v, FULL_SCALE - s);
         q = scaled_product(v, FULL_SCALE - scaled_product(s, offset));
         t = scaled_product(v, FULL_SCALE - scaled_product(s, FULL_SCALE - offset));
         case (region)
            REGION_RED_YELLOW:   color = '{v, t, p};
            REGION_YELLOW_GREEN: color = '{q, v, p};
            REGION_GREEN_CYAN:   color = '{p, v, t};
            REGION_CYAN_BLUE:    color = '{p, q, v};
            REGION_BLUE_MAGENTA: color = '{t, p, v};
            default:             color = '{v, p, q};
         endcase
      end
      return color;
   endfunction

   // Send one request; entered and left at a falling edge
   task automatic send_request(input logic [7:0] h, input logic [7:0] s,
                               input logic [7:0] v, input rgb_type color);
      if (idle_enabled && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= h;
      req_saturation <= s;
      req_brightness <= v;
      do @(posedge clock); while (req_stall);
      expected_colors.push_back(color);
      requests_sent++;
      if (s == 8'd0) grey_requests++;
      @(negedge clock);
   endtask

   // Mostly random levels, with zero, one and full scale mixed in
   function automatic logic [7:0] pick_level();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'd0;
      if (roll < 18) return 8'd255;
      if (roll < 24) return 8'd1;
      return 8'($urandom);
   endfunction

   // Result stall, idle at random outside the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= idle_enabled && ($urandom_range(99) < 30);
   end

   // Result checker
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $display("%0t: expected no result, actual r=%0d g=%0d b=%0d",
                     $time, rsp_red, rsp_green, rsp_blue);
            mismatch_count++;
         end else begin
            want = expected_colors.pop_front();
            colors_checked++;
            if (rsp_red !== want.red) begin
               $display("%0t: red expected %0d actual %0d", $time, want.red, rsp_red);
               mismatch_count++;
            end
            if (rsp_green !== want.green) begin
               $display("%0t: green expected %0d actual %0d", $time, want.green, rsp_green);
               mismatch_count++;
            end
            if (rsp_blue !== want.blue) begin
               $display("%0t: blue expected %0d actual %0d", $time, want.blue, rsp_blue);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      logic [7:0] h;
      logic [7:0] s;
      logic [7:0] v;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].hue, directed_rows[i].saturation,
                      directed_rows[i].brightness,
                      directed_rows[i].typed ? directed_rows[i].color :
                      convert_hsv(directed_rows[i].hue, directed_rows[i].saturation,
                                  directed_rows[i].brightness));
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         // back-to-back stretch with no idling on either side
         idle_enabled = !(n >= 500 && n < 800);
         h = 8'($urandom);
         s = pick_level();
         v = pick_level();
         send_request(h, s, v, convert_hsv(h, s, v));
      end
      req_valid <= 1'b0;
      idle_enabled = 1'b1;

      wait (expected_colors.size() == 0);
      repeat (10) @(posedge clock);
      $display("Converted %0d requests (%0d grey) and checked %0d colors.",
               requests_sent, grey_requests, colors_checked);
      if (mismatch_count == 0 && expected_colors.size() == 0)
         $display("hsv_to_rgb_8bit_core: match");
      else
         $display("hsv_to_rgb_8bit_core: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timed out with %0d colors outstanding.", expected_colors.size());
      $display("hsv_to_rgb_8bit_core: mismatch");
      $finish;
   end

endmodule
